### rtl/core/rwts_pkg.sv
// shared types and constants for the raycast wall texel shader
package rwts_pkg;

    // item action codes
    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_COLUMN = 2'd1,
        ACT_ROW    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam int TEX_W  = 3;   // texture number width
    localparam int D_W    = 14;  // signed row offset width
    localparam int MAG_W  = 12;  // magnitude of halved row offset
    localparam int HALF_W = 11;  // half of line height

    localparam logic [23:0] HALF_MASK = 24'd8355711;
    localparam logic [23:0] BLACK     = 24'h000000;

    // request to the row divider
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [HALF_W-1:0] half;
    } div_ctrl_t;

    // answer from the row divider
    typedef struct packed {
        logic done;
        logic in_range;
    } div_status_t;

endpackage

### rtl/core/rwts_row_divider.sv
// bit-serial divider that turns the halved row offset into a texel row
module rwts_row_divider #(
    parameter int TEXTURE_SIZE = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rwts_pkg::div_ctrl_t                  ctrl,
    output rwts_pkg::div_status_t                status,
    output logic [$clog2(TEXTURE_SIZE)-2:0]      texel_row
);
    import rwts_pkg::*;

    localparam int LOG_SIZE = $clog2(TEXTURE_SIZE);
    localparam int QW       = LOG_SIZE - 1;
    localparam int CW       = $clog2(LOG_SIZE);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } div_state_t;

    div_state_t        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [HALF_W-1:0] rem_reg, rem_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic              range_reg, range_next;

    logic [HALF_W:0]   rem2;
    logic              ge;

    always_comb
    begin
        rem2       = {rem_reg, 1'b0};
        ge         = rem2 >= {1'b0, half_reg};
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        half_next  = half_reg;
        quo_next   = quo_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        range_next = range_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (ctrl.start)
                begin
                    half_next = ctrl.half;
                    neg_next  = ctrl.neg;
                    quo_next  = '0;
                    // quotient reaches half the texture exactly when mag >= half
                    if (ctrl.mag >= {1'b0, ctrl.half})
                    begin
                        done_next  = 1'b1;
                        range_next = 1'b0;
                    end
                    else
                    begin
                        rem_next   = ctrl.mag[HALF_W-1:0];
                        cnt_next   = CW'(QW - 1);
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = ge ? HALF_W'(rem2 - {1'b0, half_reg}) : rem2[HALF_W-1:0];
                quo_next = {quo_reg[QW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    // a negative offset only lands on the texture when it truncates to zero
                    range_next = neg_reg ? (quo_next == '0) : 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            range_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            range_reg <= range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        half_reg <= half_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
    end

    assign status.done     = done_reg;
    assign status.in_range = range_reg;
    assign texel_row       = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == D_IDLE)
        else $error("divider done while still running");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("divider state not one-hot");

endmodule

### rtl/core/raycast_wall_texel_shader.sv
// top level of the raycast wall texel shader
//
//  channel  direction  handshake          payload
//  in       to block   in_valid/in_stall  action, texel_address, texel_data, wall_is_door,
//                                         wall_side, player_position_signs,
//                                         ray_direction_signs, wall_frac, line_height,
//                                         vertical_shift, row
//  out      from block out_valid/out_stall pixel_color, texel_hit
//
// write and column items give no result
// a row item goes through the prep, start and wait states, and on through the read
// state when the range check passes; the bit-serial divider forms one texel row bit a
// cycle, and skips that run when the range check already rules the row out
// reset clears the column registers (height to 2) and control state; the texel store is not cleared
// in_stall is high while a row item is in flight or its result waits for the output
// register; a result held there under out_stall does not block the next item
module raycast_wall_texel_shader #(
    parameter int TEXTURE_SIZE = 64,
    parameter int SCREEN_ROWS  = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [14:0] texel_address,
    input  logic [23:0] texel_data,
    input  logic        wall_is_door,
    input  logic        wall_side,
    input  logic [1:0]  player_position_signs,
    input  logic [1:0]  ray_direction_signs,
    input  logic [15:0] wall_frac,
    input  logic [11:0] line_height,
    input  logic signed [10:0] vertical_shift,
    input  logic [8:0]  row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] pixel_color,
    output logic        texel_hit
);
    import rwts_pkg::*;

    localparam int LOG_SIZE    = $clog2(TEXTURE_SIZE);
    localparam int QW          = LOG_SIZE - 1;
    localparam int AW          = TEX_W + 2 * LOG_SIZE;
    localparam int STORE_DEPTH = 8 * TEXTURE_SIZE * TEXTURE_SIZE;
    localparam int EXT_W       = (AW >= 15) ? AW + 1 : 16;
    localparam logic signed [D_W-1:0] HALF_ROWS = D_W'(SCREEN_ROWS / 2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic                 out_pend_reg, out_pend_next;

    // column registers
    logic [TEX_W-1:0]     tex_reg, tex_next;
    logic [LOG_SIZE-1:0]  tx_reg, tx_next;
    logic                 shaded_reg, shaded_next;
    logic [11:0]          height_reg, height_next;
    logic signed [10:0]   shift_reg, shift_next;

    // row work registers
    logic [8:0]           row_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [HALF_W-1:0]    half_reg;
    logic                 hit_reg, hit_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [23:0]          color_reg;
    logic                 texel_hit_reg;

    // texel store
    logic [23:0]          mem [STORE_DEPTH];
    logic [23:0]          rd_data_reg;
    logic [EXT_W-1:0]     waddr_ext;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en, rd_en;

    logic                 accept;
    logic                 mirror;
    logic [LOG_SIZE-1:0]  tx_raw;
    logic signed [D_W-1:0] d_s, q_s;
    logic [D_W-1:0]       q_mag;
    logic [23:0]          fetched;
    logic                 out_load;

    div_ctrl_t            div_ctrl;
    div_status_t          div_status;
    logic [QW-1:0]        texel_row;

    assign accept    = in_valid && !in_stall;
    // a pending result still depends on the column and row registers
    assign in_stall  = (state_reg != S_IDLE) || (out_pend_reg && !out_load);

    assign waddr_ext = EXT_W'(texel_address);
    assign wr_en     = accept && (action == ACT_WRITE) && (waddr_ext < EXT_W'(STORE_DEPTH));
    assign rd_en     = state_reg == S_READ;
    assign rd_addr   = {tex_reg, texel_row, 1'b0, tx_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr_ext[AW-1:0]] <= texel_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // column setup: texture choice and mirrored texel column
    assign tx_raw = wall_frac[15 -: LOG_SIZE];
    assign mirror = wall_side ? ray_direction_signs[1] : ray_direction_signs[0];

    always_comb
    begin
        tex_next    = tex_reg;
        tx_next     = tx_reg;
        shaded_next = shaded_reg;
        height_next = height_reg;
        shift_next  = shift_reg;
        if (accept && action == ACT_COLUMN)
        begin
            if (wall_side)
            begin
                tex_next = {wall_is_door, 1'b1, !player_position_signs[1]};
            end
            else
            begin
                tex_next = {wall_is_door, 1'b0, player_position_signs[0]};
            end
            tx_next     = mirror ? ~tx_raw : tx_raw;
            shaded_next = wall_side;
            height_next = line_height;
            shift_next  = vertical_shift;
        end
    end

    // signed row offset and its halving toward zero
    always_comb
    begin
        d_s   = $signed({{(D_W-9){1'b0}}, row_reg}) - HALF_ROWS
              + $signed({{(D_W-11){1'b0}}, height_reg[11:1]})
              - $signed({{(D_W-11){shift_reg[10]}}, shift_reg});
        q_s   = (d_s >>> 1) + $signed({{(D_W-1){1'b0}}, d_s[D_W-1] & d_s[0]});
        q_mag = q_s[D_W-1] ? D_W'(-q_s) : q_s;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row;
        end
        if (state_reg == S_PREP)
        begin
            neg_reg  <= q_s[D_W-1];
            mag_reg  <= q_mag[MAG_W-1:0];
            // heights below two divide by one
            half_reg <= (height_reg[11:1] == '0) ? HALF_W'(1) : height_reg[11:1];
        end
    end

    assign div_ctrl.start = state_reg == S_START;
    assign div_ctrl.neg   = neg_reg;
    assign div_ctrl.mag   = mag_reg;
    assign div_ctrl.half  = half_reg;

    rwts_row_divider #(
        .TEXTURE_SIZE(TEXTURE_SIZE)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .status   (div_status),
        .texel_row(texel_row)
    );

    // side-1 walls get each channel halved
    assign fetched  = shaded_reg ? ((rd_data_reg >> 1) & HALF_MASK) : rd_data_reg;
    assign out_load = out_pend_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        hit_next       = hit_reg;
        out_pend_next  = out_pend_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_pend_next  = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && action == ACT_ROW)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    hit_next = div_status.in_range;
                    if (div_status.in_range)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_pend_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                out_pend_next = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // row results wait in a pending slot until the output register is free

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            tex_reg       <= '0;
            tx_reg        <= '0;
            shaded_reg    <= 1'b0;
            height_reg    <= 12'd2;
            shift_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_pend_reg  <= out_pend_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            tex_reg       <= tex_next;
            tx_reg        <= tx_next;
            shaded_reg    <= shaded_next;
            height_reg    <= height_next;
            shift_reg     <= shift_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            color_reg     <= hit_reg ? fetched : BLACK;
            texel_hit_reg <= hit_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;
    assign texel_hit   = texel_hit_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_WAIT)
        else $error("divider answer outside wait state");

    a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> hit_reg)
        else $error("texel read for a row off the texture");

    a_black_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !texel_hit_reg |-> color_reg == BLACK)
        else $error("black fill result carries a color");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_pend_reg |-> state_reg == S_IDLE)
        else $error("pending result while a row is in flight");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

endmodule

### dv/raycast_wall_texel_shader_checker.sv
// checker for the raycast wall texel shader: predicts each row pixel and compares results
`timescale 1ns / 100ps

module raycast_wall_texel_shader_checker #(
    parameter int TEXTURE_SIZE = 64,
    parameter int SCREEN_ROWS  = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [14:0] texel_address,
    input  logic [23:0] texel_data,
    input  logic        wall_is_door,
    input  logic        wall_side,
    input  logic [1:0]  player_position_signs,
    input  logic [1:0]  ray_direction_signs,
    input  logic [15:0] wall_frac,
    input  logic [11:0] line_height,
    input  logic signed [10:0] vertical_shift,
    input  logic [8:0]  row,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [23:0] pixel_color,
    input  logic        texel_hit,
    output int          mismatches,
    output int          pixels_owed
);
    import rwts_pkg::*;

    localparam int TEXELS      = TEXTURE_SIZE * TEXTURE_SIZE;
    localparam int STORE_DEPTH = 8 * TEXELS;

    typedef struct packed {
        logic [23:0] color;
        logic        hit;
    } wall_pixel_t;

    // mirror of the texel store and of the latched column
    logic [23:0]   texel_mirror [STORE_DEPTH];
    int            col_texture;
    int            col_x;
    logic          col_shaded;
    logic [11:0]   col_height;
    int            col_shift;
    wall_pixel_t   expected_pixels [$];
    wall_pixel_t   want;

    // texel row from screen row, truncating divisions as in C
    function automatic wall_pixel_t shade_row_pixel(logic [8:0] screen_row);
        int          half_h;
        int          d;
        int          t;
        logic [23:0] c;
        wall_pixel_t p;
        half_h = int'(col_height) / 2;
        d = int'(screen_row) - SCREEN_ROWS / 2 + half_h - col_shift;
        if (half_h < 1)
            half_h = 1;
        t = ((d / 2) * (TEXTURE_SIZE / 2)) / half_h;
        if (t >= 0 && 2 * t < TEXTURE_SIZE)
        begin
            c = texel_mirror[col_texture * TEXELS + TEXTURE_SIZE * 2 * t + col_x];
            if (col_shaded)
                c = (c >> 1) & HALF_MASK;
            p.color = c;
            p.hit   = 1'b1;
        end
        else
        begin
            p.color = BLACK;
            p.hit   = 1'b0;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int tex;
        int x;
        if (!rst_n)
        begin
            col_texture = 0;
            col_x       = 0;
            col_shaded  = 1'b0;
            col_height  = 12'd2;
            col_shift   = 0;
            expected_pixels.delete();
        end
        else
        begin
            // results first, so an item taken at the same edge queues behind
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result: pixel_color %06h texel_hit %0b",
                           pixel_color, texel_hit);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_color !== want.color)
                    begin
                        $error("pixel_color: expected %06h, got %06h", want.color, pixel_color);
                        mismatches++;
                    end
                    if (texel_hit !== want.hit)
                    begin
                        $error("texel_hit: expected %0b, got %0b", want.hit, texel_hit);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (action_t'(action))
                    ACT_WRITE:
                        if (int'(texel_address) < STORE_DEPTH)
                            texel_mirror[texel_address] = texel_data;
                    ACT_COLUMN:
                    begin
                        tex = wall_is_door ? 4 : 0;
                        if (!wall_side && player_position_signs[0])
                            tex += 1;
                        if (wall_side)
                            tex += player_position_signs[1] ? 2 : 3;
                        x = (int'(wall_frac) * TEXTURE_SIZE) >> 16;
                        if ((!wall_side && ray_direction_signs[0]) ||
                            (wall_side && ray_direction_signs[1]))
                            x = TEXTURE_SIZE - 1 - x;
                        col_texture = tex % 8;
                        col_x       = x;
                        col_shaded  = wall_side;
                        col_height  = line_height;
                        col_shift   = int'(vertical_shift);
                    end
                    ACT_ROW:
                        expected_pixels.push_back(shade_row_pixel(row));
                    default:
                        ;
                endcase
            end
        end
        pixels_owed = expected_pixels.size();
    end

endmodule

### dv/raycast_wall_texel_shader_test.sv
// testbench top for the raycast wall texel shader: stimulus, stalls and verdict
`timescale 1ns / 100ps

module raycast_wall_texel_shader_test;
    import rwts_pkg::*;

    localparam int TEXTURE_SIZE = 64;
    localparam int LOG_SIZE     = $clog2(TEXTURE_SIZE);
    localparam int SCREEN_ROWS  = 480;
    localparam int RANDOM_ITEMS = 1260;
    localparam int PHASES       = 4;
    // hang guard with a wide margin over a slow correct run
    localparam int CYCLE_LIMIT  = 4000000;
    // room for the longest row item and a stalled result
    localparam int TAIL_CYCLES  = 40;

    // one input item, every field of the channel
    typedef struct {
        action_t            act;
        logic [14:0]        addr;
        logic [23:0]        data;
        logic               door;
        logic               side;
        logic [1:0]         pos;
        logic [1:0]         dir;
        logic [15:0]        frac;
        logic [11:0]        height;
        logic signed [10:0] shift;
        logic [8:0]         row;
    } wall_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [14:0]        texel_address;
    logic [23:0]        texel_data;
    logic               wall_is_door;
    logic               wall_side;
    logic [1:0]         player_position_signs;
    logic [1:0]         ray_direction_signs;
    logic [15:0]        wall_frac;
    logic [11:0]        line_height;
    logic signed [10:0] vertical_shift;
    logic [8:0]         row;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        pixel_color;
    logic               texel_hit;
    int                 mismatches;
    int                 pixels_owed;
    int                 cycle_count;

    raycast_wall_texel_shader #(
        .TEXTURE_SIZE (TEXTURE_SIZE),
        .SCREEN_ROWS  (SCREEN_ROWS)
    ) i_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .action                (action),
        .texel_address         (texel_address),
        .texel_data            (texel_data),
        .wall_is_door          (wall_is_door),
        .wall_side             (wall_side),
        .player_position_signs (player_position_signs),
        .ray_direction_signs   (ray_direction_signs),
        .wall_frac             (wall_frac),
        .line_height           (line_height),
        .vertical_shift        (vertical_shift),
        .row                   (row),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .pixel_color           (pixel_color),
        .texel_hit             (texel_hit)
    );

    // watches both channels and keeps the running mismatch count
    raycast_wall_texel_shader_checker #(
        .TEXTURE_SIZE (TEXTURE_SIZE),
        .SCREEN_ROWS  (SCREEN_ROWS)
    ) i_texel_checker (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .action                (action),
        .texel_address         (texel_address),
        .texel_data            (texel_data),
        .wall_is_door          (wall_is_door),
        .wall_side             (wall_side),
        .player_position_signs (player_position_signs),
        .ray_direction_signs   (ray_direction_signs),
        .wall_frac             (wall_frac),
        .line_height           (line_height),
        .vertical_shift        (vertical_shift),
        .row                   (row),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .pixel_color           (pixel_color),
        .texel_hit             (texel_hit),
        .mismatches            (mismatches),
        .pixels_owed           (pixels_owed)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("raycast_wall_texel_shader_test: done, errors");
            $finish;
        end
    end

    // idle length: zero unless the roll lands at or above quiet_pct,
    // then mostly short, now and then long
    function automatic int idle_cycles(int quiet_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < quiet_pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // every field random, so unused fields toggle too
    function automatic wall_item_t noise_item();
        wall_item_t it;
        it.act    = action_t'($urandom_range(0, 3));
        it.addr   = 15'($urandom);
        it.data   = 24'($urandom);
        it.door   = 1'($urandom);
        it.side   = 1'($urandom);
        it.pos    = 2'($urandom);
        it.dir    = 2'($urandom);
        it.frac   = 16'($urandom);
        it.height = 12'($urandom);
        it.shift  = 11'($urandom);
        it.row    = 9'($urandom_range(0, SCREEN_ROWS - 1));
        return it;
    endfunction

    function automatic wall_item_t write_item(logic [14:0] addr, logic [23:0] data);
        wall_item_t it;
        it      = noise_item();
        it.act  = ACT_WRITE;
        it.addr = addr;
        it.data = data;
        return it;
    endfunction

    function automatic wall_item_t column_item(logic door, logic side, logic [1:0] pos,
                                               logic [1:0] dir, logic [15:0] frac,
                                               logic [11:0] height, int shift);
        wall_item_t it;
        it        = noise_item();
        it.act    = ACT_COLUMN;
        it.door   = door;
        it.side   = side;
        it.pos    = pos;
        it.dir    = dir;
        it.frac   = frac;
        it.height = height;
        it.shift  = 11'(shift);
        return it;
    endfunction

    function automatic wall_item_t row_item(int screen_row);
        wall_item_t it;
        it     = noise_item();
        it.act = ACT_ROW;
        it.row = 9'(screen_row);
        return it;
    endfunction

    // present one item after an optional gap and hold it until taken;
    // returns at the falling edge after the accepting edge with valid still high
    task automatic push(input wall_item_t it, input int quiet_pct);
        int gap;
        gap = idle_cycles(quiet_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid              <= 1'b1;
        action                <= it.act;
        texel_address         <= it.addr;
        texel_data            <= it.data;
        wall_is_door          <= it.door;
        wall_side             <= it.side;
        player_position_signs <= it.pos;
        ray_direction_signs   <= it.dir;
        wall_frac             <= it.frac;
        line_height           <= it.height;
        vertical_shift        <= it.shift;
        row                   <= it.row;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // sender holds off until every row pixel has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pixels_owed != 0)
            @(negedge clk);
    endtask

    // result side stalls, with calm stretches now and then
    initial
    begin : result_backpressure
        int hold;
        bit calm;
        hold      = 0;
        calm      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 399) == 0)
                calm = !calm;
            if (hold == 0)
                hold = idle_cycles(calm ? 100 : 85);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int          sent;
        int          roll;
        int          runs;
        int          quiet;
        int          cur_height;
        int          cur_shift;
        int          r;
        logic [15:0] frac;
        wall_item_t  it;

        rst_n                 = 1'b0;
        in_valid              = 1'b0;
        action                = ACT_NONE;
        texel_address         = '0;
        texel_data            = '0;
        wall_is_door          = 1'b0;
        wall_side             = 1'b0;
        player_position_signs = '0;
        ray_direction_signs   = '0;
        wall_frac             = '0;
        line_height           = 12'd2;
        vertical_shift        = '0;
        row                   = '0;
        sent                  = 0;
        cur_height            = 2;
        cur_shift             = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // preload: rows are only ever fetched at even texel rows, and every column
        // item lands on the first or last texel column, so filling those keeps all
        // later fetches on written texels
        for (int tex = 0; tex < 8; tex++)
            for (int trow = 0; trow < TEXTURE_SIZE; trow += 2)
                for (int x = 0; x < TEXTURE_SIZE; x += TEXTURE_SIZE - 1)
                    push(write_item(15'(tex * TEXTURE_SIZE * TEXTURE_SIZE
                                        + trow * TEXTURE_SIZE + x), 24'($urandom)), 90);
        drain();

        // directed: column state straight from reset, screen row extremes
        push(row_item(SCREEN_ROWS / 2), 60);
        push(row_item(0), 60);
        push(row_item(SCREEN_ROWS - 1), 60);
        // plain x-facing wall, no mirroring
        push(column_item(1'b0, 1'b0, 2'd0, 2'd0, 16'h0000, 12'd2, 0), 60);
        push(row_item(SCREEN_ROWS / 2), 60);
        // player x below cell, ray x positive mirrors full fraction, tallest wall
        push(column_item(1'b0, 1'b0, 2'd1, 2'd1, 16'hFFFF, 12'd4095, -1024), 60);
        push(row_item(0), 60);
        push(row_item(SCREEN_ROWS - 1), 60);
        // door on a shaded y wall, ray y negative mirrors
        push(column_item(1'b1, 1'b1, 2'd2, 2'd2, 16'h03FF, 12'd64, 1023), 60);
        push(row_item(SCREEN_ROWS - 1), 60);
        push(row_item(0), 60);
        // small height falls back to divisor one
        push(column_item(1'b1, 1'b1, 2'd0, 2'd0, 16'hFFC0, 12'd1, 0), 60);
        push(row_item(SCREEN_ROWS / 2), 60);
        push(row_item(SCREEN_ROWS / 2 + 1), 60);
        push(column_item(1'b0, 1'b1, 2'd3, 2'd1, 16'h0200, 12'd0, 0), 60);
        push(row_item(SCREEN_ROWS / 2), 60);
        // height 64: d of -1 truncates to texel row zero, d of 64 runs past the texture
        push(column_item(1'b0, 1'b0, 2'd2, 2'd2, 16'hFC00, 12'd64, 0), 60);
        push(row_item(207), 60);
        push(row_item(208), 60);
        push(row_item(271), 60);
        push(row_item(272), 60);
        // overwrite the texel read for row 208 and read it back
        push(write_item(15'(TEXTURE_SIZE - 1), 24'hFFFFFF), 60);
        push(row_item(208), 60);
        // unknown action is dropped
        it     = noise_item();
        it.act = ACT_NONE;
        push(it, 60);
        push(row_item(SCREEN_ROWS / 2), 60);
        drain();

        // random phases, each ending with a full drain
        for (int phase = 0; phase < PHASES; phase++)
        begin
            while (sent < (phase + 1) * RANDOM_ITEMS / PHASES)
            begin
                quiet = ($urandom_range(0, 5) == 0) ? 100 : 60;
                roll  = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    // well-formed: a column then a run of rows, mostly over its span
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        cur_height = $urandom_range(0, 1);
                    else if (r < 15)
                        cur_height = $urandom_range(2, 16);
                    else if (r < 80)
                        cur_height = $urandom_range(2, 400);
                    else
                        cur_height = $urandom_range(400, 4095);
                    if ($urandom_range(0, 9) < 7)
                        cur_shift = $urandom_range(0, 240) - 120;
                    else
                        cur_shift = $urandom_range(0, 2047) - 1024;
                    // fraction lands on the first or last texel column, low bits random
                    frac                 = 16'($urandom);
                    frac[15 -: LOG_SIZE] = {LOG_SIZE{1'($urandom_range(0, 1))}};
                    push(column_item(1'($urandom), 1'($urandom), 2'($urandom),
                                     2'($urandom), frac, 12'(cur_height), cur_shift),
                         quiet);
                    sent++;
                    runs = $urandom_range(1, 24);
                    repeat (runs)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            r = $urandom_range(0, SCREEN_ROWS - 1);
                        else
                            r = SCREEN_ROWS / 2 - cur_height / 2 + cur_shift
                                + $urandom_range(0, cur_height + 8) - 4;
                        if (r < 0)
                            r = 0;
                        if (r > SCREEN_ROWS - 1)
                            r = SCREEN_ROWS - 1;
                        push(row_item(r), quiet);
                        sent++;
                    end
                end
                else if (roll < 85)
                begin
                    // retexture a few random texels
                    runs = $urandom_range(1, 4);
                    repeat (runs)
                    begin
                        push(write_item(15'($urandom), 24'($urandom)), quiet);
                        sent++;
                    end
                end
                else if (roll < 92)
                begin
                    // ignored action, not counted
                    it     = noise_item();
                    it.act = ACT_NONE;
                    push(it, quiet);
                end
                else
                begin
                    // stray rows on whatever column is latched
                    runs = $urandom_range(1, 6);
                    repeat (runs)
                    begin
                        push(row_item($urandom_range(0, SCREEN_ROWS - 1)), quiet);
                        sent++;
                    end
                end
            end
            drain();
        end

        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pixels_owed == 0)
            $display("raycast_wall_texel_shader_test: done, clean");
        else
            $display("raycast_wall_texel_shader_test: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/rwts_pkg.sv
rtl/core/rwts_row_divider.sv
rtl/core/raycast_wall_texel_shader.sv
dv/raycast_wall_texel_shader_checker.sv
dv/raycast_wall_texel_shader_test.sv
